FILE: sv/vca_pkg.sv
// Shared types and constants of the voice channel allocator.
// Holds the request kinds, result status codes, sequencer states and result record.
// No dependencies.
package vca_pkg;

  localparam int TAG_W  = 8;
  localparam int KIND_W = 2;
  localparam int VIN_W  = 5;
  localparam int VIDX_W = 5;
  localparam int STAT_W = 2;

  // Request kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FINISH  = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_SWEEP   = 2'd3
  } kind_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_DROPPED   = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_STEAL,
    S_TAG_RD,
    S_TAKE,
    S_DONE
  } state_t;

  // One result record, handed from the sequencer to the output register.
  typedef struct packed {
    logic              granted;
    logic [VIDX_W-1:0] voice_index;
    logic              evicted_valid;
    logic [TAG_W-1:0]  evicted_tag;
    status_t           status;
  } rsp_t;

endpackage

FILE: sv/vca_req_if.sv
// Request channel of the voice channel allocator: valid, ready and one request.
// Depends on vca_pkg for the field widths.
interface vca_req_if;
  import vca_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [TAG_W-1:0]    tag;
  logic                priority_req;
  logic [VIN_W-1:0]    voice;

  modport source (output valid, kind, tag, priority_req, voice, input ready);
  modport sink   (input valid, kind, tag, priority_req, voice, output ready);
endinterface

FILE: sv/vca_rsp_if.sv
// Result channel of the voice channel allocator: valid, ready and one result.
// Depends on vca_pkg for the field widths.
interface vca_rsp_if;
  import vca_pkg::*;

  logic                valid;
  logic                ready;
  logic                granted;
  logic [VIDX_W-1:0]   voice_index;
  logic                evicted_valid;
  logic [TAG_W-1:0]    evicted_tag;
  logic [STAT_W-1:0]   status;

  modport source (output valid, granted, voice_index, evicted_valid, evicted_tag, status,
                  input ready);
  modport sink   (input valid, granted, voice_index, evicted_valid, evicted_tag, status,
                  output ready);
endinterface

FILE: sv/voice_channel_allocator.sv
// Voice channel allocator. One request at a time: a finished-voice mark or a sweep of
// finished voices needs no search; a release scans the tag memory, one voice per
// cycle, and stops at the first match; an allocation scans the tags the same way,
// then, without a tag match, searches from the round-robin cursor for a silent voice
// and then for an unprotected one, one voice per cycle, then reads and rewrites the
// chosen voice's tag. The single read port of the tag memory sets the scan rate.
// Each request yields one result, held in an output register, and the next request
// may enter while that result waits.
module voice_channel_allocator #(
  parameter int NUM_VOICES = 32
) (
  input  logic      clk,
  input  logic      rst,
  vca_req_if.sink   req,
  vca_rsp_if.source rsp
);
  import vca_pkg::*;

  localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  logic             tag_wr_en;
  logic [IW-1:0]    tag_wr_addr;
  logic [TAG_W-1:0] tag_wr_data;
  logic [IW-1:0]    tag_rd_addr;
  logic [TAG_W-1:0] tag_rd_data;
  logic             res_valid;
  logic             res_ready;
  rsp_t             res;

  // Tag memory, one entry per voice.
  vca_ram #(
    .WIDTH (TAG_W),
    .DEPTH (NUM_VOICES)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (tag_wr_en),
    .wr_addr (tag_wr_addr),
    .wr_data (tag_wr_data),
    .rd_addr (tag_rd_addr),
    .rd_data (tag_rd_data)
  );

  // Search sequencer and voice flags.
  vca_seq #(
    .NUM_VOICES (NUM_VOICES)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .tag_wr_en   (tag_wr_en),
    .tag_wr_addr (tag_wr_addr),
    .tag_wr_data (tag_wr_data),
    .tag_rd_addr (tag_rd_addr),
    .tag_rd_data (tag_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // Output register.
  vca_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rsp       (rsp)
  );

`ifndef NO_ASSERTIONS
  // A result handed to the output register shows up on the port next cycle.
  a_handoff: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> rsp.valid)
    else $error("result handed over but not presented");

  // An eviction is only ever reported with a grant.
  a_evict_granted: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.evicted_valid |-> res.granted)
    else $error("eviction without grant");

  // A dropped allocation carries neither grant nor eviction.
  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_DROPPED |-> !res.granted && !res.evicted_valid)
    else $error("dropped result carries a grant");

  // A granted result always has status done.
  a_grant_status: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.granted |-> rsp.status == ST_DONE)
    else $error("granted result with error status");
`endif

endmodule

FILE: sv/vca_ram.sv
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module vca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/vca_seq.sv
// Sequencer of the voice channel allocator: voice flags, round-robin cursor and the
// one-voice-per-cycle search. Depends on vca_pkg, vca_req_if and the tag memory ports.
module vca_seq #(
  parameter int NUM_VOICES = 32,
  localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1,
  localparam int CW = $clog2(NUM_VOICES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  vca_req_if.sink               req,
  output logic                  tag_wr_en,
  output logic [IW-1:0]         tag_wr_addr,
  output logic [vca_pkg::TAG_W-1:0] tag_wr_data,
  output logic [IW-1:0]         tag_rd_addr,
  input  logic [vca_pkg::TAG_W-1:0] tag_rd_data,
  output logic                  res_valid,
  input  logic                  res_ready,
  output vca_pkg::rsp_t         res
);
  import vca_pkg::*;

  localparam logic [IW-1:0] LAST = IW'(NUM_VOICES - 1);

  state_t                  state, state_next;
  logic [CW-1:0]           cnt, cnt_next;
  logic                    pvld, pvld_next;
  logic [IW-1:0]           pidx, pidx_next;
  logic [IW-1:0]           sel, sel_next;
  logic [IW-1:0]           srch, srch_next;
  logic [IW-1:0]           xcnt, xcnt_next;
  logic [IW-1:0]           cursor, cursor_next;
  logic                    move_cursor, move_cursor_next;
  kind_t                   req_kind, req_kind_next;
  logic [TAG_W-1:0]        req_tag, req_tag_next;
  logic                    req_prio, req_prio_next;
  logic [NUM_VOICES-1:0]   busy, busy_next;
  logic [NUM_VOICES-1:0]   playing, playing_next;
  logic [NUM_VOICES-1:0]   prot, prot_next;
  logic [NUM_VOICES-1:0]   sweep_mask;
  rsp_t                    res_next;
  logic [IW-1:0]           fin_idx;
  logic                    fin_in_range;
  logic                    tag_hit;

  // Next voice in round-robin order.
  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx);
    logic [IW-1:0] nxt;
    nxt = (idx == LAST) ? '0 : idx + 1'b1;
    return nxt;
  endfunction

  assign fin_idx      = IW'(req.voice);
  assign fin_in_range = int'(req.voice) < NUM_VOICES;
  assign sweep_mask   = busy & ~playing;
  assign tag_hit      = pvld && busy[pidx] && (tag_rd_data == req_tag);
  assign res_valid    = (state == S_DONE);
  assign req.ready    = (state == S_IDLE);

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      pvld        <= 1'b0;
      cursor      <= '0;
      move_cursor <= 1'b0;
      busy        <= '0;
      playing     <= '0;
      prot        <= '0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      pvld        <= pvld_next;
      cursor      <= cursor_next;
      move_cursor <= move_cursor_next;
      busy        <= busy_next;
      playing     <= playing_next;
      prot        <= prot_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pidx     <= pidx_next;
    sel      <= sel_next;
    srch     <= srch_next;
    xcnt     <= xcnt_next;
    req_kind <= req_kind_next;
    req_tag  <= req_tag_next;
    req_prio <= req_prio_next;
    res      <= res_next;
  end

  // Next state, flag updates and memory control.
  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    pvld_next        = pvld;
    pidx_next        = pidx;
    sel_next         = sel;
    srch_next        = srch;
    xcnt_next        = xcnt;
    cursor_next      = cursor;
    move_cursor_next = move_cursor;
    req_kind_next    = req_kind;
    req_tag_next     = req_tag;
    req_prio_next    = req_prio;
    busy_next        = busy;
    playing_next     = playing;
    prot_next        = prot;
    res_next         = res;
    tag_wr_en        = 1'b0;
    tag_wr_addr      = sel;
    tag_wr_data      = req_tag;
    tag_rd_addr      = cnt[IW-1:0];

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          req_kind_next = kind_t'(req.kind);
          req_tag_next  = req.tag;
          req_prio_next = req.priority_req;
          res_next      = '0;
          cnt_next      = '0;
          pvld_next     = 1'b0;
          unique case (kind_t'(req.kind))
            KIND_ALLOC, KIND_RELEASE: begin
              state_next = S_SCAN;
            end
            KIND_FINISH: begin
              if (fin_in_range) begin
                playing_next[fin_idx] = 1'b0;
              end
              state_next = S_DONE;
            end
            KIND_SWEEP: begin
              busy_next    = busy & ~sweep_mask;
              playing_next = playing & ~sweep_mask;
              prot_next    = prot & ~sweep_mask;
              state_next   = S_DONE;
            end
          endcase
        end
      end

      // Tag scan: one memory read issued per cycle, compared in the cycle after the read.
      S_SCAN: begin
        if (cnt < CW'(NUM_VOICES)) begin
          cnt_next  = cnt + 1'b1;
          pvld_next = 1'b1;
          pidx_next = cnt[IW-1:0];
        end else begin
          pvld_next = 1'b0;
        end
        if (tag_hit) begin
          pvld_next = 1'b0;
          sel_next  = pidx;
          if (req_kind == KIND_ALLOC) begin
            move_cursor_next = 1'b0;
            state_next       = S_TAG_RD;
          end else begin
            busy_next[pidx]      = 1'b0;
            playing_next[pidx]   = 1'b0;
            prot_next[pidx]      = 1'b0;
            res_next.voice_index = VIDX_W'(pidx);
            res_next.status      = ST_DONE;
            state_next           = S_DONE;
          end
        end else if (pvld && pidx == LAST) begin
          pvld_next = 1'b0;
          if (req_kind == KIND_ALLOC) begin
            srch_next  = cursor;
            xcnt_next  = '0;
            state_next = S_FREE;
          end else begin
            res_next.status = ST_NOT_FOUND;
            state_next      = S_DONE;
          end
        end
      end

      // Round-robin search for a voice that is not playing.
      S_FREE: begin
        if (!(busy[srch] && playing[srch])) begin
          sel_next         = srch;
          move_cursor_next = 1'b1;
          state_next       = S_TAG_RD;
        end else if (xcnt == LAST) begin
          srch_next  = cursor;
          xcnt_next  = '0;
          state_next = S_STEAL;
        end else begin
          srch_next = wrap_inc(srch);
          xcnt_next = xcnt + 1'b1;
        end
      end

      // Round-robin search for a voice whose sound may be stolen.
      S_STEAL: begin
        if (!(busy[srch] && prot[srch])) begin
          sel_next         = srch;
          move_cursor_next = 1'b1;
          state_next       = S_TAG_RD;
        end else if (xcnt == LAST) begin
          res_next.status = ST_DROPPED;
          state_next      = S_DONE;
        end else begin
          srch_next = wrap_inc(srch);
          xcnt_next = xcnt + 1'b1;
        end
      end

      // Fetch the tag the chosen voice holds now.
      S_TAG_RD: begin
        tag_rd_addr = sel;
        state_next  = S_TAKE;
      end

      // Hand the voice to the new sound.
      S_TAKE: begin
        tag_wr_en              = 1'b1;
        res_next.granted       = 1'b1;
        res_next.voice_index   = VIDX_W'(sel);
        res_next.evicted_valid = busy[sel];
        res_next.evicted_tag   = busy[sel] ? tag_rd_data : '0;
        res_next.status        = ST_DONE;
        busy_next[sel]         = 1'b1;
        playing_next[sel]      = 1'b1;
        prot_next[sel]         = req_prio;
        if (move_cursor) begin
          cursor_next = wrap_inc(sel);
        end
        state_next = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/vca_out_reg.sv
// Output register of the voice channel allocator: holds one result for the consumer.
// Depends on vca_pkg and vca_rsp_if.
module vca_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          res_valid,
  output logic          res_ready,
  input  vca_pkg::rsp_t res,
  vca_rsp_if.source     rsp
);
  import vca_pkg::*;

  rsp_t held;

  assign res_ready = !rsp.valid || rsp.ready;

  // Valid flag of the held result.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_ready) begin
      rsp.valid <= res_valid;
    end
  end

  // Result payload, loaded when the slot frees up.
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      held <= res;
    end
  end

  assign rsp.granted       = held.granted;
  assign rsp.voice_index   = held.voice_index;
  assign rsp.evicted_valid = held.evicted_valid;
  assign rsp.evicted_tag   = held.evicted_tag;
  assign rsp.status        = held.status;

endmodule
